>>> hdl/rdc_pkg.sv
// Shared constants, types and helper functions for the radix digit converter.
`default_nettype none

package rdc_pkg;

  // Field and storage sizes
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int COUNT_W     = 6;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int STEP_W = $clog2(VALUE_WIDTH);

  // Radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  // Highest digit value with a glyph
  localparam logic [DIGIT_W-1:0] DIGIT_TOP = DIGIT_W'(35);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [RADIX_W-1:0]     radix_t;
  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [COUNT_W-1:0]     count_t;

  // Clamp a written base into 2..36
  function automatic radix_t clamp_radix(input radix_t v);
    radix_t r;
    if (v < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      r = RADIX_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Digit value to ASCII: '0'-'9' then 'A'-'Z'
  function automatic char_t digit_glyph(input digit_t d);
    digit_t dc;
    char_t  c;
    dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
    if (dc < DIGIT_W'(10)) begin
      c = CHAR_W'(8'h30) + CHAR_W'(dc);
    end else begin
      c = CHAR_W'(8'h37) + CHAR_W'(dc);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rdc_channels.sv
// Handshake channel interfaces for the radix digit converter.
`default_nettype none

// Configuration write channel: one register, no index
interface rdc_cfg_if;
  logic                  valid;
  logic                  ready;
  rdc_pkg::radix_t       data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Input channel: one value per beat
interface rdc_value_if;
  logic                  valid;
  logic                  ready;
  rdc_pkg::value_t       value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one digit per beat
interface rdc_digit_if;
  logic                  valid;
  logic                  ready;
  rdc_pkg::char_t        digit_char;
  rdc_pkg::count_t       digit_count;
  logic                  last_digit;
  modport source (output valid, output digit_char, output digit_count, output last_digit,
                  input ready);
  modport sink   (input valid, input digit_char, input digit_count, input last_digit,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/radix_digit_converter.sv
// Radix digit converter top level: sequencer, shared divider step and digit store.
`default_nettype none

// Converts one unsigned value per conversion into its digits in the base held in
// the radix register (2..36, written values clamped; reset 10), emitted most
// significant first as ASCII '0'-'9','A'-'Z', each beat carrying the digit count
// and a mark on the final digit. Zero gives the single digit '0'. Each digit is
// produced by a restoring divide that runs one quotient bit per cycle through a
// single compare-subtract unit; digits are then read back from a 32-entry store,
// each beat passing through a read state and then a show state that holds until
// the sink takes it. The input is not ready until the last digit beat has been
// taken. Radix writes are taken at any time but must only be made while the
// block is idle.
module radix_digit_converter (
  input  wire             clk,
  input  wire             rst,
  rdc_cfg_if.sink         cfg,
  rdc_value_if.sink       number,
  rdc_digit_if.source     digit
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_SHOW = 2'd3;

  localparam int VW = rdc_pkg::VALUE_WIDTH;
  localparam int RW = rdc_pkg::RADIX_W;

  logic [1:0]                  state;
  rdc_pkg::radix_t             radix;
  rdc_pkg::value_t             quotient_work;
  rdc_pkg::digit_t             rem;
  logic [rdc_pkg::STEP_W-1:0]  step;
  logic [rdc_pkg::CNT_W-1:0]   digit_total;
  logic [rdc_pkg::IDX_W-1:0]   rd_idx;
  rdc_pkg::digit_t             rd_data;

  rdc_pkg::digit_t             digit_store [rdc_pkg::MAX_DIGITS];

  // Shared compare-subtract step
  logic [RW:0]                 rem_sh;
  logic                        fits;
  rdc_pkg::digit_t             rem_next;
  rdc_pkg::value_t             quotient_next;
  logic [rdc_pkg::CNT_W-1:0]   total_next;
  logic                        last_step;

  assign rem_sh        = {rem, quotient_work[VW-1]};
  assign fits          = rem_sh >= {1'b0, radix};
  assign rem_next      = fits ? rdc_pkg::DIGIT_W'(rem_sh - {1'b0, radix})
                              : rdc_pkg::DIGIT_W'(rem_sh);
  assign quotient_next = {quotient_work[VW-2:0], fits};
  assign total_next    = digit_total + rdc_pkg::CNT_W'(1);
  assign last_step     = step == rdc_pkg::STEP_W'(VW - 1);

  // Handshakes
  assign cfg.ready    = 1'b1;
  assign number.ready = state == ST_IDLE;

  // Result beat
  assign digit.valid       = state == ST_SHOW;
  assign digit.digit_char  = rdc_pkg::digit_glyph(rd_data);
  assign digit.digit_count = rdc_pkg::COUNT_W'(digit_total);
  assign digit.last_digit  = rd_idx == '0;

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      radix <= rdc_pkg::clamp_radix(cfg.data);
    end
  end

  // Sequencer and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      quotient_work <= '0;
      digit_total   <= '0;
      step          <= '0;
      rd_idx        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (number.valid) begin
            quotient_work <= number.value;
            digit_total   <= '0;
            step          <= '0;
            state         <= ST_DIV;
          end
        end
        ST_DIV: begin
          quotient_work <= quotient_next;
          step          <= step + rdc_pkg::STEP_W'(1);
          if (last_step) begin
            digit_total <= total_next;
            if (quotient_next == '0 ||
                total_next == rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS)) begin
              rd_idx <= digit_total[rdc_pkg::IDX_W-1:0];
              state  <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (digit.ready) begin
            if (rd_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx - rdc_pkg::IDX_W'(1);
              state  <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Partial remainder, cleared at the start of each digit
  always_ff @(posedge clk) begin
    if (state == ST_IDLE || (state == ST_DIV && last_step)) begin
      rem <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_next;
    end
  end

  // Digit store: written at the end of each divide, read back during output
  always_ff @(posedge clk) begin
    if (state == ST_DIV && last_step) begin
      digit_store[digit_total[rdc_pkg::IDX_W-1:0]] <= rem_next;
    end
    if (state == ST_READ) begin
      rd_data <= digit_store[rd_idx];
    end
  end

  // Checks
  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < radix))
    else $error("partial remainder not below radix");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(number.ready && digit.valid))
    else $error("input ready while a digit beat is offered");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    digit.valid |-> (digit.digit_count != '0))
    else $error("digit beat with zero digit count");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (digit.valid && digit.ready && digit.last_digit) |=> number.ready)
    else $error("input not ready after the final digit beat");

endmodule

`default_nettype wire

>>> bench/radix_digit_converter_test.sv
// Self-checking bench for the radix digit converter: value in, digit beats out.
module radix_digit_converter_test;

  localparam int IDLE_PCT     = 38;
  localparam int PHASE_ITEMS  = 35;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 500;
  localparam int QUIET_LIMIT  = 8000;
  localparam int SETTLE       = 40;

  typedef struct packed {
    rdc_pkg::char_t  ch;
    rdc_pkg::count_t total;
    logic            is_last;
  } digit_beat_t;

  logic clk;
  logic rst;

  rdc_cfg_if   cfg_ch ();
  rdc_value_if value_ch ();
  rdc_digit_if digit_ch ();

  radix_digit_converter u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .number (value_ch),
    .digit  (digit_ch)
  );

  digit_beat_t      expected_digits[$];
  rdc_pkg::value_t  pending_values[$];
  string       glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
  int unsigned active_base;
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  int unsigned errors;
  bit          steady;
  bit          hold_done;
  bit          value_taken;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Base as the block holds it after a write
  function automatic int unsigned clamp_base(input int unsigned v);
    if (v < 2) return 2;
    if (v > 36) return 36;
    return v;
  endfunction

  // Divide down by the current base, then queue the digits most significant first
  function automatic void predict_digits(input rdc_pkg::value_t v);
    int unsigned rems[$];
    int unsigned q;
    digit_beat_t b;
    int          n;
    q = v;
    if (q == 0) begin
      rems.push_back(0);
    end else begin
      while (q != 0 && rems.size() < rdc_pkg::MAX_DIGITS) begin
        rems.push_back(q % active_base);
        q = q / active_base;
      end
    end
    n = rems.size();
    for (int k = n - 1; k >= 0; k--) begin
      b.ch      = rdc_pkg::char_t'(glyph_set[rems[k]]);
      b.total   = rdc_pkg::count_t'(n);
      b.is_last = (k == 0);
      expected_digits.push_back(b);
    end
  endfunction

  // Random value biased towards short results, powers of the base and the ends
  function automatic rdc_pkg::value_t pick_value(input int unsigned base);
    int unsigned    pick;
    int unsigned    k;
    longint unsigned p;
    pick = $urandom_range(99);
    if (pick < 30) return $urandom();
    if (pick < 50) return $urandom_range(base * base);
    if (pick < 65) begin
      p = 1;
      k = $urandom_range(31);
      while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
        p = p * base;
        k--;
      end
      return rdc_pkg::value_t'(p - $urandom_range(1));
    end
    if (pick < 75) return $urandom_range(1) ? '0 : '1;
    return $urandom() >> $urandom_range(31);
  endfunction

  // Accepted beats on all three channels: model update, check, prediction, watchdog
  always @(posedge clk) begin
    digit_beat_t want;
    bit          any_beat;
    any_beat = 1'b0;
    value_taken = 1'b0;
    if (rst) begin
      active_base = rdc_pkg::RADIX_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        active_base = clamp_base(cfg_ch.data);
        any_beat = 1'b1;
      end
      if (digit_ch.valid && digit_ch.ready) begin
        any_beat = 1'b1;
        if (expected_digits.size() == 0) begin
          errors++;
          $display("%0t: digit beat with none expected: char %h count %0d last %b",
                   $time, digit_ch.digit_char, digit_ch.digit_count, digit_ch.last_digit);
        end else begin
          want = expected_digits.pop_front();
          if (digit_ch.digit_char !== want.ch) begin
            errors++;
            $display("%0t: digit_char expected %h actual %h", $time, want.ch,
                     digit_ch.digit_char);
          end
          if (digit_ch.digit_count !== want.total) begin
            errors++;
            $display("%0t: digit_count expected %0d actual %0d", $time, want.total,
                     digit_ch.digit_count);
          end
          if (digit_ch.last_digit !== want.is_last) begin
            errors++;
            $display("%0t: last_digit expected %b actual %b", $time, want.is_last,
                     digit_ch.last_digit);
          end
        end
      end
      if (value_ch.valid && value_ch.ready) begin
        predict_digits(value_ch.value);
        items_taken++;
        value_taken = 1'b1;
        any_beat = 1'b1;
      end
    end
    quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("radix_digit_converter_test: errors");
      $finish;
    end
  end

  // Value driver: hold each beat until taken, random gaps between beats
  always @(negedge clk) begin
    if (rst) begin
      value_ch.valid <= 1'b0;
    end else if (!value_ch.valid || value_taken) begin
      if (pending_values.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        value_ch.valid <= 1'b1;
        value_ch.value <= pending_values.pop_front();
      end else begin
        value_ch.valid <= 1'b0;
      end
    end
  end

  // Digit receiver: random stalls, and one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      digit_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      digit_ch.ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT && digit_ch.valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      digit_ch.ready <= 1'b0;
    end else begin
      digit_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  task automatic queue_value(input rdc_pkg::value_t v);
    pending_values.push_back(v);
    items_queued++;
  endtask

  // Wait until every value is taken and every digit has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || expected_digits.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_radix(input rdc_pkg::radix_t r);
    wait_drained();
    @(negedge clk);
    cfg_ch.data  <= r;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned radix_plan[12];
    int unsigned r;
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    digit_ch.ready = 1'b0;
    errors         = 0;
    items_queued   = 0;
    items_taken    = 0;
    quiet_cycles   = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    steady         = 1'b0;
    radix_plan     = '{2, 3, 7, 8, 16, 36, 35, 10, 0, 0, 63, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset base of ten: zero, digit rollover, field ends
    queue_value(0);
    queue_value(1);
    queue_value(9);
    queue_value(10);
    queue_value(99);
    queue_value(100);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(1000000000);

    // Base written as zero clamps to two: longest result of 32 digits
    write_radix(0);
    queue_value(0);
    queue_value(1);
    queue_value(2);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);

    // All ones clamps to 36: top glyph 'Z'
    write_radix(63);
    queue_value(0);
    queue_value(35);
    queue_value(36);
    queue_value(1295);
    queue_value(32'hFFFF_FFFF);

    // Just above the top and just below the bottom
    write_radix(37);
    queue_value(35);
    queue_value(36);
    write_radix(1);
    queue_value(3);

    // Random phases over a spread of bases, one without any idling
    for (int p = 0; p < 12; p++) begin
      r = (p == 8 || p == 9) ? $urandom_range(63) : radix_plan[p];
      write_radix(rdc_pkg::radix_t'(r));
      steady = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_value(pick_value(active_base));
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("radix_digit_converter_test: clean");
    end else begin
      $display("radix_digit_converter_test: errors");
    end
    $finish;
  end

endmodule
